>>> rtl/core/kls_pkg.sv
// kls_pkg: shared types and constants for the k-th largest stream tracker
// no dependencies
`timescale 1ns / 1ps

package kls_pkg;

  localparam int DATA_W = 32;
  localparam int RANK_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_PLACE,
    ST_FINISH
  } kls_state_t;

endpackage

>>> rtl/core/kth_largest_stream_tracker.sv
// kth_largest_stream_tracker: k-th largest value of a signed stream, min-heap in memory
// depends on kls_pkg
`timescale 1ns / 1ps

// One result beat per input beat: the heap root, which is the k-th largest value seen
// once k values have arrived (the smallest so far before that), plus heap_full. The heap
// lives in a single-port-write, single-port-read memory with registered read data, and
// one compare unit walks it under a small sequencer, holding the moving value in a
// register. An input that grows the heap sifts up (parent read, compare per level); an
// input that replaces the root sifts down (left child read, right child read, compare
// per level); an input not above the root is dropped. in_stall is high while an item is
// in work; a finished result waits in the output register while the next item is taken.
// rank_k of 0 acts as 1, above MAX_RANK saturates.
module kth_largest_stream_tracker
  import kls_pkg::*;
#(
  parameter int MAX_RANK = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [RANK_W-1:0]        cfg_write_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] new_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] kth_value,
  output logic                     heap_full
);

  localparam int AW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int CW  = $clog2(MAX_RANK + 1);
  localparam int CXW = AW + 2;

  kls_state_t state, state_next;

  logic [RANK_W-1:0]        rank_k;
  logic [CW-1:0]            heap_count, count_next;
  logic [CW-1:0]            k_eff;
  logic [AW-1:0]            pos, pos_next;
  logic signed [DATA_W-1:0] cur, cur_next;
  logic signed [DATA_W-1:0] left_q;
  logic signed [DATA_W-1:0] root;
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] mem [MAX_RANK];

  logic                     we, re, out_load, in_acc;
  logic [AW-1:0]            wa, ra, parent;
  logic signed [DATA_W-1:0] wd;
  logic [CXW-1:0]           l_idx, r_idx, n_x;
  logic                     has_l, has_r, take_l, take_r;
  logic signed [DATA_W-1:0] min_lv;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    if (rank_k == '0) begin
      k_eff = CW'(1);
    end else if (32'(rank_k) > 32'(MAX_RANK)) begin
      k_eff = CW'(MAX_RANK);
    end else begin
      k_eff = CW'(rank_k);
    end
  end

  assign parent = AW'((pos - AW'(1)) >> 1);
  assign l_idx  = CXW'({pos, 1'b1});
  assign r_idx  = CXW'({pos, 1'b0}) + CXW'(2);
  assign n_x    = CXW'(heap_count);
  assign has_l  = (l_idx < n_x);
  assign has_r  = (r_idx < n_x);
  assign take_l = (left_q < cur);
  assign min_lv = take_l ? left_q : cur;
  assign take_r = has_r && (rd_data < min_lv);

  always_comb begin
    state_next = state;
    pos_next   = pos;
    cur_next   = cur;
    count_next = heap_count;
    we         = 1'b0;
    wa         = pos;
    wd         = cur;
    re         = 1'b0;
    ra         = pos;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          cur_next = new_value;
          if (heap_count < k_eff) begin
            count_next = heap_count + CW'(1);
            pos_next   = AW'(heap_count);
            state_next = (heap_count == '0) ? ST_PLACE : ST_UP_RD;
          end else if (root < new_value) begin
            pos_next   = '0;
            state_next = ST_DN_RDL;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_UP_RD: begin
        re         = 1'b1;
        ra         = parent;
        state_next = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if (cur < rd_data) begin
          we         = 1'b1;
          wd         = rd_data;
          pos_next   = parent;
          state_next = (parent == '0) ? ST_PLACE : ST_UP_RD;
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_DN_RDL: begin
        if (has_l) begin
          re         = 1'b1;
          ra         = AW'(l_idx);
          state_next = ST_DN_RDR;
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_DN_RDR: begin
        if (has_r) begin
          re = 1'b1;
          ra = AW'(r_idx);
        end
        state_next = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (take_l || take_r) begin
          we         = 1'b1;
          wd         = take_r ? rd_data : left_q;
          pos_next   = take_r ? AW'(r_idx) : AW'(l_idx);
          state_next = ST_DN_RDL;
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        we         = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // heap storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      heap_count <= '0;
      rank_k     <= RANK_W'(1);
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      heap_count <= count_next;
      if (cfg_write_en) begin
        rank_k <= cfg_write_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    cur <= cur_next;
    if (state == ST_DN_RDR) begin
      left_q <= rd_data;
    end
    if (we && wa == '0) begin
      root <= wd;
    end
    if (out_load) begin
      kth_value <= root;
      heap_full <= (heap_count >= k_eff);
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst)
    heap_count <= CW'(MAX_RANK))
    else $error("heap count beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != ST_IDLE))
    else $error("accepted beat not taken into work");

  assert property (@(posedge clk) disable iff (rst)
    (heap_count != $past(heap_count)) |-> $past(in_acc || rst))
    else $error("heap count changed without an input beat");

  assert property (@(posedge clk) disable iff (rst)
    we |-> (CW'(wa) < heap_count))
    else $error("write outside the live heap");

  assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == ST_IDLE))
    else $error("result load lost");

endmodule

>>> tb/kth_largest_stream_tracker_tb.sv
// kth_largest_stream_tracker_tb: self-checking bench for the k-th largest stream tracker
// runs a min-heap predictor beside the block and checks every result beat against it
// depends on kls_pkg and kth_largest_stream_tracker
`timescale 1ns / 1ps

module kth_largest_stream_tracker_tb;
  import kls_pkg::*;

  localparam int HEAP_DEPTH     = 64;
  localparam int SETTLE_CYCLES  = 40;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     wait_drain;
  } stream_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] kth;
    logic                     full;
  } root_report_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write_en = 1'b0;
  logic [RANK_W-1:0]        cfg_write_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] new_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] kth_value;
  logic                     heap_full;

  stream_beat_t             beat_q[$];
  root_report_t             root_q[$];
  logic signed [DATA_W-1:0] heap_mem [HEAP_DEPTH];
  int unsigned              heap_cnt = 0;
  logic [RANK_W-1:0]        rank_reg = 7'd1;
  int                       send_idle_pct = 30;
  int                       recv_stall_pct = 70;
  int                       mismatches = 0;
  int                       cycles = 0;

  kth_largest_stream_tracker #(
    .MAX_RANK(HEAP_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .new_value     (new_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kth_value     (kth_value),
    .heap_full     (heap_full)
  );

  always #2 clk = ~clk;

  function automatic int unsigned rank_in_use();
    if (rank_reg == 0) return 1;
    if (rank_reg > HEAP_DEPTH) return HEAP_DEPTH;
    return 32'(rank_reg);
  endfunction

  function automatic root_report_t heap_absorb(logic signed [DATA_W-1:0] v);
    int unsigned              k;
    int unsigned              pos;
    int unsigned              up;
    int unsigned              l;
    int unsigned              r;
    int unsigned              m;
    logic signed [DATA_W-1:0] t;
    root_report_t             rep;
    k = rank_in_use();
    if (heap_cnt < k) begin
      pos = heap_cnt;
      heap_mem[pos] = v;
      heap_cnt++;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (heap_mem[pos] >= heap_mem[up]) break;
        t = heap_mem[pos];
        heap_mem[pos] = heap_mem[up];
        heap_mem[up] = t;
        pos = up;
      end
    end else if (heap_mem[0] < v) begin
      heap_mem[0] = v;
      pos = 0;
      while (pos < heap_cnt) begin
        l = 2 * pos + 1;
        r = 2 * pos + 2;
        m = pos;
        if (l < heap_cnt && heap_mem[l] < heap_mem[m]) m = l;
        if (r < heap_cnt && heap_mem[r] < heap_mem[m]) m = r;
        if (m == pos) break;
        t = heap_mem[pos];
        heap_mem[pos] = heap_mem[m];
        heap_mem[m] = t;
        pos = m;
      end
    end
    rep.kth = heap_mem[0];
    rep.full = (heap_cnt >= k);
    return rep;
  endfunction

  // input beats: predict on acceptance, then present the next queued value
  always @(posedge clk) begin : drive
    stream_beat_t nxt;
    logic         hold;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && in_stall;
      if (in_valid && !in_stall) root_q = {root_q, heap_absorb(new_value)};
      if (!hold) begin
        if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct &&
            !(beat_q[0].wait_drain && root_q.size() > 0)) begin
          nxt = beat_q.pop_front();
          in_valid <= 1'b1;
          new_value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result beats: compare with the oldest prediction
  always @(posedge clk) begin : check
    root_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (root_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: kth_value %0d heap_full %0b", kth_value, heap_full);
        end else begin
          want = root_q.pop_front();
          if (kth_value !== want.kth || heap_full !== want.full) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: kth_value %0d (exp %0d) heap_full %0b (exp %0b)",
                       kth_value, want.kth, heap_full, want.full);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("kth_largest_stream_tracker_tb: errors");
      $finish;
    end
  end

  task automatic add_beat(input logic signed [DATA_W-1:0] v, input logic drain);
    stream_beat_t b;
    b.value = v;
    b.wait_drain = drain;
    beat_q = {beat_q, b};
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom_range(16) - 8;
      1: begin
        if ($urandom_range(1) == 0) v = 32'sh7fffffff - $urandom_range(3);
        else v = 32'sh80000000 + $urandom_range(3);
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_random(input int n);
    repeat (n) add_beat(pick_value(), $urandom_range(49) == 0);
  endtask

  task automatic wait_idle();
    while (beat_q.size() != 0 || in_valid || root_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rank(input logic [RANK_W-1:0] v);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    rank_reg = v;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // rank 1 from reset, field extremes
    add_beat(32'sh00000000, 1'b0);
    add_beat(32'sh7fffffff, 1'b0);
    add_beat(32'sh80000000, 1'b0);
    add_beat(-32'sd1, 1'b0);
    add_beat(32'sh00000001, 1'b0);
    add_beat(32'sh7fffffff, 1'b1);
    add_beat(32'sh80000000, 1'b0);
    wait_idle();

    // rank zero acts as one
    set_rank(7'd0);
    add_beat(32'sd3, 1'b0);
    add_beat(-32'sd3, 1'b0);
    add_beat(32'sd3, 1'b0);
    add_beat(32'sh7ffffffe, 1'b1);
    add_beat(32'sh80000001, 1'b0);
    wait_idle();

    set_rank(7'd6);
    add_random(40);
    wait_idle();

    // lowered mid-stream
    set_rank(7'd2);
    add_random(50);
    wait_idle();

    // raised mid-stream
    set_idling(70, 30);
    set_rank(7'd20);
    add_random(70);
    wait_idle();

    // above capacity saturates
    set_rank(7'd127);
    add_random(120);
    wait_idle();

    set_idling(0, 0);
    set_rank(7'd64);
    add_random(80);
    wait_idle();

    set_rank(7'd1);
    add_random(40);
    wait_idle();

    repeat (3) begin
      set_rank(RANK_W'($urandom_range(127)));
      add_random(50);
      wait_idle();
    end

    if (mismatches == 0) $display("kth_largest_stream_tracker_tb: clean");
    else $display("kth_largest_stream_tracker_tb: errors");
    $finish;
  end

endmodule
